// File: hdl/assert_macros.svh
// Assertion macros shared by the tap and stroke detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// File: hdl/itsd_pkg.sv
// Types and constants of the tap and stroke detector
package itsd_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned WINDOW_DEF  = 30;
  localparam int unsigned MAX_CAL     = 4096;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned ACC_W       = 2 * SAMPLE_BITS;
  localparam int unsigned CNT_W       = $clog2(MAX_CAL + 1);
  localparam int unsigned CSUM_W      = 29;
  localparam int unsigned CSQ_W       = 45;
  localparam int unsigned MUL_W       = 29;
  localparam int unsigned PROD_W      = 2 * MUL_W;
  localparam int unsigned DEN_W       = 2 * CNT_W;
  localparam int unsigned SQ_LO_W     = 23;
  localparam int unsigned HOLD_W      = 6;
  localparam int unsigned TM_W        = 8;
  localparam int unsigned LIMIT_W     = 20;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;

  localparam logic [TM_W-1:0]    TAP_MULT_RST     = 8'd48;
  localparam logic [LIMIT_W-1:0] STROKE_LIMIT_RST = 20'd100000;
  localparam logic [HOLD_W-1:0]  TAP_HOLD_RST     = 6'd15;
  localparam logic [HOLD_W-1:0]  STROKE_HOLD_RST  = 6'd25;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_TAP   = 3'd1,
    GEST_UP    = 3'd2,
    GEST_DOWN  = 3'd3,
    GEST_LEFT  = 3'd4,
    GEST_RIGHT = 3'd5
  } gesture_e;

  typedef enum logic [1:0] {
    REG_TAP_MULT     = 2'd0,
    REG_STROKE_LIMIT = 2'd1,
    REG_TAP_HOLD     = 2'd2,
    REG_STROKE_HOLD  = 2'd3
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SQSUM,
    ST_ROOT,
    ST_MAGSQ,
    ST_TAPM,
    ST_DETECT,
    ST_F_MEAN,
    ST_F_NLO,
    ST_F_NHI,
    ST_F_SQ,
    ST_F_DEN,
    ST_F_DIVGO,
    ST_F_VAR,
    ST_F_ROOT,
    ST_DONE
  } state_e;

endpackage

// File: hdl/itsd_cell.sv
// One window cell: holds an x/y sample pair and passes it on when shifting
module itsd_cell #(
  parameter int unsigned W = itsd_pkg::SAMPLE_BITS
) (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o
);
  logic signed [W-1:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
endmodule

// File: hdl/itsd_div.sv
// Restoring divider, one quotient bit per cycle
module itsd_div #(
  parameter int unsigned DVD_W = itsd_pkg::PROD_W,
  parameter int unsigned DVS_W = itsd_pkg::DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);
  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [DVS_W:0]   rem_sh;
  logic             geq;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign geq    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= geq ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], geq};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

// File: hdl/itsd_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle
module itsd_sqrt #(
  parameter int unsigned RAD_W = itsd_pkg::PROD_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   rad_i,
  output logic               done_o,
  output logic [RAD_W/2-1:0] root_o
);
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CW     = $clog2(ROOT_W + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_sh, trial;
  logic [ROOT_W-1:0] root_q;
  logic              geq;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign geq    = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= geq ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], geq};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// File: hdl/imu_tap_stroke_detector.sv
// Top level of the IMU tap and stroke detector
// A sample result passes the square states, the 29-step root unit, the tap product and detection.
// A stop-calibration item runs up to two 58-step divider passes and one root pass;
// other commands go straight to the done state.
// One item at a time; output stalls hold the result and delay the next transaction.
// Reset: asynchronous, active low; control and configuration registers return to their defaults.
`include "assert_macros.svh"

module imu_tap_stroke_detector #(
  parameter int unsigned WINDOW = itsd_pkg::WINDOW_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            req_type_i,
  input  logic signed [itsd_pkg::SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [itsd_pkg::SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [itsd_pkg::SAMPLE_BITS-1:0] accel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            gesture_o,
  output logic [itsd_pkg::MAG_W-1:0]            sample_magnitude_o,
  output logic                                  is_calibrated_o,
  output logic [itsd_pkg::MAG_W-1:0]            mean_level_o,
  output logic [itsd_pkg::MAG_W-1:0]            spread_level_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [itsd_pkg::ADDR_W-1:0]           paddr,
  input  logic [itsd_pkg::DATA_W-1:0]           pwdata,
  output logic [itsd_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import itsd_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam int unsigned TAP_W  = MAG_W + 6;

  state_e state_q, state_d;
  req_e   req_q;
  logic   accept, out_free;

  logic signed [SAMPLE_BITS-1:0] x_q, y_q, z_q;
  logic [SAMPLE_BITS-1:0]        ux, uy, uz;
  logic [ACC_W-1:0]              acc_q;
  logic [MUL_W-1:0]              mul_a, mul_b;
  logic [PROD_W-1:0]             prod_q, num_q;
  logic [MAG_W-1:0]              mag_q;
  gesture_e                      gest_q, gest_d;

  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [FILL_W-1:0]       fill_q;
  logic [HOLD_W-1:0]       hold_q, hold_d;

  logic               cal_active_q, cal_valid_q;
  logic [CNT_W-1:0]   cal_count_q;
  logic [CSUM_W-1:0]  cal_sum_q;
  logic [CSQ_W-1:0]   cal_sumsq_q;
  logic [MAG_W-1:0]   mean_q, spread_q;

  logic [TM_W-1:0]    tap_mult_q;
  logic [LIMIT_W-1:0] stroke_limit_q;
  logic [HOLD_W-1:0]  tap_hold_q, stroke_hold_q;

  logic             ov_q;
  gesture_e         o_gest_q;
  logic [MAG_W-1:0] o_mag_q, o_mean_q, o_spread_q;
  logic             o_cal_q;

  logic              div_start, div_done;
  logic [PROD_W-1:0] div_dvd, div_q;
  logic [DEN_W-1:0]  div_dvs;
  logic              sqrt_start, sqrt_done;
  logic [PROD_W-1:0] sqrt_rad;
  logic [MUL_W-1:0]  sqrt_root;

  logic signed [SAMPLE_BITS-1:0] cx [WINDOW+1];
  logic signed [SAMPLE_BITS-1:0] cy [WINDOW+1];
  logic                          shift_en, win_full;

  logic signed [TAP_W-1:0] tap_lhs;
  logic                    tap_hit;
  logic [SUM_W-1:0]        ax, ay;
  logic                    stroke_hit;
  logic                    cfg_wr;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;
  assign out_free   = !ov_q || !out_stall_i;
  assign win_full   = fill_q == FILL_W'(WINDOW);
  assign shift_en   = state_q == ST_TAPM;

  assign ux = x_q[SAMPLE_BITS-1] ? $unsigned(-x_q) : $unsigned(x_q);
  assign uy = y_q[SAMPLE_BITS-1] ? $unsigned(-y_q) : $unsigned(y_q);
  assign uz = z_q[SAMPLE_BITS-1] ? $unsigned(-z_q) : $unsigned(z_q);

  // window shift chain, last cell holds the sample leaving the window
  assign cx[0] = x_q;
  assign cy[0] = y_q;
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    itsd_cell #(.W(SAMPLE_BITS)) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_en),
      .x_i    (cx[i]),
      .y_i    (cy[i]),
      .x_o    (cx[i+1]),
      .y_o    (cy[i+1])
    );
  end

  itsd_div #(.DVD_W(PROD_W), .DVS_W(DEN_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  itsd_sqrt #(.RAD_W(PROD_W)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .rad_i  (sqrt_rad),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_e'(req_type_i))
            REQ_SAMPLE: state_d = ST_SQX;
            REQ_STOP:   state_d = (cal_count_q != '0) ? ST_F_MEAN : ST_DONE;
            REQ_START,
            REQ_CLEAR:  state_d = ST_DONE;
          endcase
        end
      end
      ST_SQX:     state_d = ST_SQY;
      ST_SQY:     state_d = ST_SQZ;
      ST_SQZ:     state_d = ST_SQSUM;
      ST_SQSUM:   state_d = ST_ROOT;
      ST_ROOT:    if (sqrt_done) state_d = ST_MAGSQ;
      ST_MAGSQ:   state_d = ST_TAPM;
      ST_TAPM:    state_d = ST_DETECT;
      ST_DETECT:  state_d = ST_DONE;
      ST_F_MEAN: begin
        if (div_done) state_d = (cal_count_q < CNT_W'(2)) ? ST_DONE : ST_F_NLO;
      end
      ST_F_NLO:   state_d = ST_F_NHI;
      ST_F_NHI:   state_d = ST_F_SQ;
      ST_F_SQ:    state_d = ST_F_DEN;
      ST_F_DEN:   state_d = ST_F_DIVGO;
      ST_F_DIVGO: state_d = ST_F_VAR;
      ST_F_VAR:   if (div_done) state_d = ST_F_ROOT;
      ST_F_ROOT:  if (sqrt_done) state_d = ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // unit controls and shared multiplier operands
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    sqrt_start = 1'b0;
    sqrt_rad   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && req_e'(req_type_i) == REQ_STOP && cal_count_q != '0) begin
          div_start = 1'b1;
          div_dvd   = PROD_W'(cal_sum_q);
          div_dvs   = DEN_W'(cal_count_q);
        end
      end
      ST_SQX: begin
        mul_a = MUL_W'(ux);
        mul_b = MUL_W'(ux);
      end
      ST_SQY: begin
        mul_a = MUL_W'(uy);
        mul_b = MUL_W'(uy);
      end
      ST_SQZ: begin
        mul_a = MUL_W'(uz);
        mul_b = MUL_W'(uz);
      end
      ST_SQSUM: begin
        sqrt_start = 1'b1;
        sqrt_rad   = PROD_W'(acc_q) + prod_q;
      end
      ST_MAGSQ: begin
        mul_a = MUL_W'(mag_q);
        mul_b = MUL_W'(mag_q);
      end
      ST_TAPM: begin
        mul_a = MUL_W'(tap_mult_q);
        mul_b = MUL_W'(spread_q);
      end
      ST_F_NLO: begin
        mul_a = MUL_W'(cal_count_q);
        mul_b = MUL_W'(cal_sumsq_q[SQ_LO_W-1:0]);
      end
      ST_F_NHI: begin
        mul_a = MUL_W'(cal_count_q);
        mul_b = MUL_W'(cal_sumsq_q[CSQ_W-1:SQ_LO_W]);
      end
      ST_F_SQ: begin
        mul_a = MUL_W'(cal_sum_q);
        mul_b = MUL_W'(cal_sum_q);
      end
      ST_F_DEN: begin
        mul_a = MUL_W'(cal_count_q);
        mul_b = MUL_W'(cal_count_q - CNT_W'(1));
      end
      ST_F_DIVGO: begin
        div_start = 1'b1;
        div_dvd   = num_q;
        div_dvs   = prod_q[DEN_W-1:0];
      end
      ST_F_VAR: begin
        sqrt_start = div_done;
        sqrt_rad   = div_q;
      end
      default: ;
    endcase
  end

  // detection
  assign tap_lhs = $signed({2'b00, mag_q, 4'b0000}) - $signed({2'b00, mean_q, 4'b0000});
  assign tap_hit = $signed({{4{tap_lhs[TAP_W-1]}}, tap_lhs})
                 > $signed({2'b00, prod_q[TM_W+MAG_W-1:0]});
  assign ax = sum_x_q[SUM_W-1] ? $unsigned(-sum_x_q) : $unsigned(sum_x_q);
  assign ay = sum_y_q[SUM_W-1] ? $unsigned(-sum_y_q) : $unsigned(sum_y_q);
  assign stroke_hit = win_full && ((CMP_W'(ax) > CMP_W'(stroke_limit_q))
                                || (CMP_W'(ay) > CMP_W'(stroke_limit_q)));

  always_comb begin
    gest_d = GEST_NONE;
    hold_d = hold_q;
    if (cal_valid_q) begin
      priority if (hold_q != '0) begin
        hold_d = hold_q - HOLD_W'(1);
      end else if (tap_hit) begin
        gest_d = GEST_TAP;
        hold_d = tap_hold_q;
      end else if (stroke_hit) begin
        hold_d = stroke_hold_q;
        if (ax > ay) begin
          gest_d = (sum_x_q > 0) ? GEST_RIGHT : GEST_LEFT;
        end else begin
          gest_d = (sum_y_q > 0) ? GEST_UP : GEST_DOWN;
        end
      end else begin
        gest_d = GEST_NONE;
      end
    end
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      sum_x_q        <= '0;
      sum_y_q        <= '0;
      fill_q         <= '0;
      hold_q         <= '0;
      cal_active_q   <= 1'b0;
      cal_valid_q    <= 1'b0;
      cal_count_q    <= '0;
      cal_sum_q      <= '0;
      cal_sumsq_q    <= '0;
      mean_q         <= '0;
      spread_q       <= '0;
      tap_mult_q     <= TAP_MULT_RST;
      stroke_limit_q <= STROKE_LIMIT_RST;
      tap_hold_q     <= TAP_HOLD_RST;
      stroke_hold_q  <= STROKE_HOLD_RST;
      ov_q           <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (reg_e'(paddr[3:2]))
          REG_TAP_MULT:     tap_mult_q     <= pwdata[TM_W-1:0];
          REG_STROKE_LIMIT: stroke_limit_q <= pwdata[LIMIT_W-1:0];
          REG_TAP_HOLD:     tap_hold_q     <= pwdata[HOLD_W-1:0];
          REG_STROKE_HOLD:  stroke_hold_q  <= pwdata[HOLD_W-1:0];
        endcase
      end
      if (ov_q && !out_stall_i && state_q != ST_DONE) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (req_e'(req_type_i))
              REQ_SAMPLE: ;
              REQ_START: begin
                cal_active_q <= 1'b1;
                cal_valid_q  <= 1'b0;
                cal_count_q  <= '0;
                cal_sum_q    <= '0;
                cal_sumsq_q  <= '0;
              end
              REQ_STOP: cal_active_q <= 1'b0;
              REQ_CLEAR: begin
                cal_active_q <= 1'b0;
                cal_valid_q  <= 1'b0;
                cal_count_q  <= '0;
                cal_sum_q    <= '0;
                cal_sumsq_q  <= '0;
                mean_q       <= '0;
                spread_q     <= '0;
              end
            endcase
          end
        end
        ST_TAPM: begin
          if (win_full) begin
            sum_x_q <= sum_x_q + SUM_W'(x_q) - SUM_W'(cx[WINDOW]);
            sum_y_q <= sum_y_q + SUM_W'(y_q) - SUM_W'(cy[WINDOW]);
          end else begin
            sum_x_q <= sum_x_q + SUM_W'(x_q);
            sum_y_q <= sum_y_q + SUM_W'(y_q);
            fill_q  <= fill_q + FILL_W'(1);
          end
          if (cal_active_q && cal_count_q < CNT_W'(MAX_CAL)) begin
            cal_count_q <= cal_count_q + CNT_W'(1);
            cal_sum_q   <= cal_sum_q + CSUM_W'(mag_q);
            cal_sumsq_q <= cal_sumsq_q + CSQ_W'(prod_q[2*MAG_W-1:0]);
          end
        end
        ST_DETECT: hold_q <= hold_d;
        ST_F_MEAN: begin
          if (div_done) begin
            mean_q <= div_q[MAG_W-1:0];
            if (cal_count_q < CNT_W'(2)) begin
              spread_q    <= '0;
              cal_valid_q <= 1'b1;
            end
          end
        end
        ST_F_ROOT: begin
          if (sqrt_done) begin
            spread_q    <= sqrt_root[MAG_W-1:0];
            cal_valid_q <= 1'b1;
          end
        end
        ST_DONE: if (out_free) ov_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      req_q  <= req_e'(req_type_i);
      x_q    <= accel_x_i;
      y_q    <= accel_y_i;
      z_q    <= accel_z_i;
      mag_q  <= '0;
      gest_q <= GEST_NONE;
    end
    unique case (state_q)
      ST_SQY:   acc_q <= prod_q[ACC_W-1:0];
      ST_SQZ:   acc_q <= acc_q + prod_q[ACC_W-1:0];
      ST_ROOT:  if (sqrt_done) mag_q <= sqrt_root[MAG_W-1:0];
      ST_DETECT: gest_q <= (req_q == REQ_SAMPLE) ? gest_d : GEST_NONE;
      ST_F_NHI: num_q <= prod_q;
      ST_F_SQ:  num_q <= num_q + (prod_q << SQ_LO_W);
      ST_F_DEN: num_q <= (num_q > prod_q) ? (num_q - prod_q) : '0;
      ST_DONE: begin
        if (out_free) begin
          o_gest_q   <= gest_q;
          o_mag_q    <= mag_q;
          o_cal_q    <= cal_valid_q;
          o_mean_q   <= mean_q;
          o_spread_q <= spread_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    prdata = '0;
    unique case (reg_e'(paddr[3:2]))
      REG_TAP_MULT:     prdata = DATA_W'(tap_mult_q);
      REG_STROKE_LIMIT: prdata = DATA_W'(stroke_limit_q);
      REG_TAP_HOLD:     prdata = DATA_W'(tap_hold_q);
      REG_STROKE_HOLD:  prdata = DATA_W'(stroke_hold_q);
    endcase
  end

  assign pready             = 1'b1;
  assign out_valid_o        = ov_q;
  assign gesture_o          = o_gest_q;
  assign sample_magnitude_o = o_mag_q;
  assign is_calibrated_o    = o_cal_q;
  assign mean_level_o       = o_mean_q;
  assign spread_level_o     = o_spread_q;

  `ASSERT_CLK(a_fill_max, clk_i, rst_ni, fill_q <= FILL_W'(WINDOW))
  `ASSERT_CLK(a_cal_max, clk_i, rst_ni, cal_count_q <= CNT_W'(MAX_CAL))
  `ASSERT_CLK(a_gest_cal, clk_i, rst_ni, out_valid_o && gesture_o != GEST_NONE |-> is_calibrated_o)
  `ASSERT_NEVER(a_root_state, clk_i, rst_ni, sqrt_done && state_q != ST_ROOT && state_q != ST_F_ROOT)
  `ASSERT_NEVER(a_div_state, clk_i, rst_ni, div_done && state_q != ST_F_MEAN && state_q != ST_F_VAR)
endmodule
